/* sv/ubsct_pkg.sv */
// ----------------------------------------------------------------------------
// ubsct_pkg: shared types for the union-by-size component tracker
// Request and result payloads, fixed field widths and sequencer states.
// ----------------------------------------------------------------------------
package ubsct_pkg;

	localparam int NODE_W  = 10;
	localparam int COUNT_W = 11;

	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

	typedef struct packed {
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} ubsct_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] component_total;
		logic [COUNT_W-1:0] largest_set;
		logic               range_error;
	} ubsct_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_COMP,
		ST_LINK,
		ST_SIZE_B,
		ST_MERGE,
		ST_DONE
	} ubsct_state_t;

endpackage

/* sv/union_by_size_component_tracker.sv */
// ----------------------------------------------------------------------------
// union_by_size_component_tracker: union-find engine, union by size
// Joins the two endpoints of each edge request and reports the component
// count and the largest set size after it.
// ----------------------------------------------------------------------------
// Usage:
//   Request: req (node_a, node_b) is taken at a clock edge with start high
//   and busy low. busy stays high while the request is worked on.
//   Result: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so the result must be taken in that cycle.
//   Configuration: cfg_we with cfg_wdata writes node_count (0 reads as 1,
//   values above MAX_NODES are capped). It starts a clearing pass.
// Timing:
//   A request with an endpoint not below node_count has done high in the
//   cycle right after acceptance, with range_error set and nothing changed.
//   Otherwise the engine walks from node_a to its root and compresses that
//   path, then does the same for node_b; with both roots equal it finishes
//   there, else it reads both set sizes and merges. Each root walk step and
//   each compression step is one read of the single read port of the parent
//   table, so the walks follow depth, the number of links from an endpoint
//   to its root. Depth stays at or below log2(node_count). One request at a
//   time: busy drops the cycle after done.
// Reset and configuration:
//   After reset and after each node_count write a clearing pass over all
//   node_count nodes makes every node a singleton; busy is high meanwhile.
// ----------------------------------------------------------------------------
module union_by_size_component_tracker
	import ubsct_pkg::*;
#(
	parameter int MAX_NODES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ubsct_req_t         req,
	output logic               done,
	output ubsct_rsp_t         result,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam logic [COUNT_W-1:0] NC_CAP = COUNT_W'(MAX_NODES);
	localparam logic [COUNT_W-1:0] NC_INIT =
		(MAX_NODES < 1024) ? COUNT_W'(MAX_NODES) : NODE_COUNT_RESET;

	ubsct_state_t state_q, state_nx;

	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] max_q;
	logic [IDX_W-1:0]   clr_q;
	logic               err_q;
	logic               side_q;
	logic [IDX_W-1:0]   a_q, b_q, cur_q, ra_q, rb_q;
	logic [COUNT_W-1:0] sa_q;

	logic [IDX_W-1:0]   par_mem [MAX_NODES];
	logic [COUNT_W-1:0] sz_mem  [MAX_NODES];
	logic [IDX_W-1:0]   par_rd_q;
	logic [COUNT_W-1:0] sz_rd_q;

	logic               par_we;
	logic [IDX_W-1:0]   par_waddr, par_wdata, par_raddr;
	logic               sz_we;
	logic [IDX_W-1:0]   sz_waddr, sz_raddr;
	logic [COUNT_W-1:0] sz_wdata;

	logic               accept;
	logic               range_bad;
	logic               clr_last;
	logic               found;
	logic [IDX_W-1:0]   root_sel;
	logic               swap;
	logic [COUNT_W-1:0] merged_size;
	logic [COUNT_W-1:0] cfg_clamped;

	assign accept    = start && (state_q == ST_IDLE);
	assign range_bad = ({1'b0, req.node_a} >= node_count_q) ||
	                   ({1'b0, req.node_b} >= node_count_q);
	assign clr_last  = (32'(clr_q) == (32'(node_count_q) - 32'd1));
	assign found     = (par_rd_q == cur_q);
	assign root_sel  = side_q ? rb_q : ra_q;
	assign swap      = (sa_q < sz_rd_q);
	assign merged_size = sa_q + sz_rd_q;

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_clamped = 11'd1;
		end else if (32'(cfg_wdata) > MAX_NODES) begin
			cfg_clamped = NC_CAP;
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nx = range_bad ? ST_DONE : ST_FIND;
			end
			ST_FIND: begin
				if (found) state_nx = ST_COMP;
			end
			ST_COMP: begin
				if (cur_q == root_sel) state_nx = side_q ? ST_LINK : ST_FIND;
			end
			ST_LINK: begin
				state_nx = (ra_q == rb_q) ? ST_DONE : ST_SIZE_B;
			end
			ST_SIZE_B: state_nx = ST_MERGE;
			ST_MERGE:  state_nx = ST_DONE;
			ST_DONE:   state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
		if (cfg_we) state_nx = ST_CLEAR;
	end

	// Table port controls and handshake outputs
	always_comb begin
		par_we    = 1'b0;
		par_waddr = cur_q;
		par_wdata = root_sel;
		par_raddr = par_rd_q;
		sz_we     = 1'b0;
		sz_waddr  = clr_q;
		sz_wdata  = 11'd1;
		sz_raddr  = ra_q;
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		case (state_q)
			ST_CLEAR: begin
				par_we    = 1'b1;
				par_waddr = clr_q;
				par_wdata = clr_q;
				sz_we     = 1'b1;
			end
			ST_IDLE: begin
				par_raddr = IDX_W'(req.node_a);
			end
			ST_FIND: begin
				// on the root, restart at the endpoint for compression
				if (found) par_raddr = side_q ? b_q : a_q;
			end
			ST_COMP: begin
				if (cur_q == root_sel) begin
					par_raddr = b_q;
				end else begin
					par_we = 1'b1;
				end
			end
			ST_LINK: begin
				sz_raddr = ra_q;
			end
			ST_SIZE_B: begin
				sz_raddr = rb_q;
			end
			ST_MERGE: begin
				// hang the smaller set under the larger, first root on a tie
				par_we    = 1'b1;
				par_waddr = swap ? ra_q : rb_q;
				par_wdata = swap ? rb_q : ra_q;
				sz_we     = 1'b1;
				sz_waddr  = swap ? rb_q : ra_q;
				sz_wdata  = merged_size;
			end
			default: begin
				par_we = 1'b0;
			end
		endcase
	end

	assign result.component_total = count_q;
	assign result.largest_set     = max_q;
	assign result.range_error     = err_q;

	// Tables
	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_waddr] <= par_wdata;
		par_rd_q <= par_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (sz_we) sz_mem[sz_waddr] <= sz_wdata;
		sz_rd_q <= sz_mem[sz_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			node_count_q <= NC_INIT;
			count_q      <= NC_INIT;
			max_q        <= 11'd1;
			clr_q        <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				node_count_q <= cfg_clamped;
				count_q      <= cfg_clamped;
				max_q        <= 11'd1;
				clr_q        <= '0;
			end else begin
				if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
				if (state_q == ST_MERGE) begin
					if (count_q > 11'd1) count_q <= count_q - 11'd1;
					if (merged_size > max_q) max_q <= merged_size;
				end
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					a_q    <= IDX_W'(req.node_a);
					b_q    <= IDX_W'(req.node_b);
					cur_q  <= IDX_W'(req.node_a);
					side_q <= 1'b0;
					err_q  <= range_bad;
				end
			end
			ST_FIND: begin
				if (found) begin
					if (side_q) rb_q <= cur_q;
					else ra_q <= cur_q;
					cur_q <= side_q ? b_q : a_q;
				end else begin
					cur_q <= par_rd_q;
				end
			end
			ST_COMP: begin
				if (cur_q == root_sel) begin
					side_q <= 1'b1;
					cur_q  <= b_q;
				end else begin
					cur_q <= par_rd_q;
				end
			end
			ST_SIZE_B: begin
				sa_q <= sz_rd_q;
			end
			default: begin
				sa_q <= sa_q;
			end
		endcase
	end

	a_err_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && range_bad && !cfg_we) |=> (done && result.range_error))
		else $error("range error request did not return an error result");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR && !cfg_we) |=> (count_q <= $past(count_q)))
		else $error("component count grew without a configuration write");

	a_result_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.largest_set <= node_count_q && result.component_total >= 11'd1))
		else $error("result counters out of bounds");

	a_merge_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (ra_q != rb_q))
		else $error("merge entered with equal roots");

endmodule
